// ===== src/mfhd_pkg.sv =====
// ----------------------------------------------------------------------------
// mfhd_pkg
// Types, codes and constant tables for the MPEG audio frame header decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mfhd_pkg;

	// status codes
	localparam logic [2:0] STAT_OK      = 3'd0;
	localparam logic [2:0] STAT_SYNC    = 3'd1;
	localparam logic [2:0] STAT_VERSION = 3'd2;
	localparam logic [2:0] STAT_LAYER   = 3'd3;
	localparam logic [2:0] STAT_BITRATE = 3'd4;
	localparam logic [2:0] STAT_RATE    = 3'd5;

	// version codes
	localparam logic [1:0] VER_25   = 2'd0;
	localparam logic [1:0] VER_RSVD = 2'd1;
	localparam logic [1:0] VER_2    = 2'd2;
	localparam logic [1:0] VER_1    = 2'd3;

	// sample rate index codes
	localparam logic [1:0] HZ_BASE44 = 2'd0;
	localparam logic [1:0] HZ_BASE48 = 2'd1;
	localparam logic [1:0] HZ_BASE32 = 2'd2;

	// divisor of the 11025 Hz family after the common factors are cancelled
	localparam logic [7:0] DIV_11K = 8'd147;

	// enables of the three divider stages
	typedef struct packed {
		logic en1;
		logic en2;
		logic en3;
	} div_ctl_t;

	// fields that ride along the pipeline
	typedef struct packed {
		logic [2:0]  status;
		logic [1:0]  ver;
		logic [1:0]  layer_num;
		logic        prot;
		logic [8:0]  kbps;
		logic [15:0] rate;
		logic        pad;
		logic [2:0]  sh;
		logic        slot4;
	} side_t;

	localparam logic [8:0] KBPS_TBL [2][3][16] = '{
		'{
			'{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
			  9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
			'{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
			  9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
			'{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
			  9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0}
		},
		'{
			'{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
			  9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
			'{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
			  9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
			'{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
			  9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
		}
	};

	// bitrate lookup, zero for the reserved layer code
	function automatic logic [8:0] kbps_lookup(input logic grp, input logic [1:0] lay,
	                                           input logic [3:0] br);
		logic [8:0] v;
		v = 9'd0;
		if (lay != 2'd3) begin
			v = KBPS_TBL[grp][lay[1:0]][br];
		end
		return v;
	endfunction

	// sampling frequency
	function automatic logic [15:0] rate_lookup(input logic [1:0] ver, input logic [1:0] hz);
		logic [15:0] r;
		case ({ver, hz})
			{VER_25, HZ_BASE44}: r = 16'd11025;
			{VER_25, HZ_BASE48}: r = 16'd12000;
			{VER_25, HZ_BASE32}: r = 16'd8000;
			{VER_2, HZ_BASE44}:  r = 16'd22050;
			{VER_2, HZ_BASE48}:  r = 16'd24000;
			{VER_2, HZ_BASE32}:  r = 16'd16000;
			{VER_1, HZ_BASE44}:  r = 16'd44100;
			{VER_1, HZ_BASE48}:  r = 16'd48000;
			{VER_1, HZ_BASE32}:  r = 16'd32000;
			default:             r = 16'd0;
		endcase
		return r;
	endfunction

	// frame size coefficient divided by twelve
	function automatic logic [3:0] coef_div12(input logic grp, input logic [1:0] lay);
		logic [3:0] c;
		case (lay)
			2'd0:    c = 4'd1;
			2'd1:    c = 4'd12;
			2'd2:    c = grp ? 4'd6 : 4'd12;
			default: c = 4'd0;
		endcase
		return c;
	endfunction

	// floor((2^32 - 1) / d) for the divisors in use
	function automatic logic [31:0] recip(input logic [7:0] d);
		logic [31:0] m;
		case (d)
			8'd3:    m = 32'd1431655765;
			8'd5:    m = 32'd858993459;
			8'd7:    m = 32'd613566756;
			8'd9:    m = 32'd477218588;
			8'd11:   m = 32'd390451572;
			8'd13:   m = 32'd330382099;
			8'd147:  m = 32'd29217464;
			default: m = 32'hffff_ffff;
		endcase
		return m;
	endfunction

	// trailing zero count of a six-bit value, zero for zero
	function automatic logic [2:0] tz6(input logic [5:0] v);
		logic [2:0] n;
		if (v[0])      n = 3'd0;
		else if (v[1]) n = 3'd1;
		else if (v[2]) n = 3'd2;
		else if (v[3]) n = 3'd3;
		else if (v[4]) n = 3'd4;
		else if (v[5]) n = 3'd5;
		else           n = 3'd0;
		return n;
	endfunction

endpackage

`default_nettype wire

// ===== src/mfhd_recip_div.sv =====
// ----------------------------------------------------------------------------
// mfhd_recip_div
// Three-stage divide of a 29-bit value by a small divisor: reciprocal
// multiply, remainder, one correction step.
// ----------------------------------------------------------------------------
`default_nettype none

module mfhd_recip_div (
	input  wire                   clk,
	input  mfhd_pkg::div_ctl_t    ctl,
	input  wire  [28:0]           x,
	input  wire  [7:0]            d,
	input  wire  [31:0]           m,
	output logic [28:0]           q
);
	import mfhd_pkg::*;

	logic [60:0] prod;
	logic [28:0] q0_s1, x_s1, q0_s2, q_s3;
	logic [7:0]  d_s1, d_s2;
	logic [36:0] qd, rem;
	logic [8:0]  rem_s2;

	// estimate, never more than one below the quotient
	assign prod = {32'd0, x} * {29'd0, m};

	always_ff @(posedge clk) begin
		if (ctl.en1) begin
			q0_s1 <= prod[60:32];
			x_s1  <= x;
			d_s1  <= d;
		end
	end

	// remainder of the estimate
	assign qd  = {8'd0, q0_s1} * {29'd0, d_s1};
	assign rem = {8'd0, x_s1} - qd;

	always_ff @(posedge clk) begin
		if (ctl.en2) begin
			rem_s2 <= rem[8:0];
			q0_s2  <= q0_s1;
			d_s2   <= d_s1;
		end
	end

	// correction
	always_ff @(posedge clk) begin
		if (ctl.en3) begin
			q_s3 <= q0_s2 + {28'd0, (rem_s2 >= {1'b0, d_s2})};
		end
	end

	assign q = q_s3;

endmodule

`default_nettype wire

// ===== src/mp3_frame_header_decode.sv =====
// ----------------------------------------------------------------------------
// mp3_frame_header_decode
// Decodes one MPEG audio frame header per item: fields, frame size and
// play time from the audio length.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  in      | in_valid / in_stall  | header_word, id3 fields, tag, length
//  out     | out_valid / out_stall| status, header fields, sizes, duration
//
// One item per cycle while the output is not stalled; the stages are decode,
// net length, then the three stages of the reciprocal dividers.
// Reset clears only the stage valid bits.
// A stalled output holds; stages with bubbles keep filling, so in_stall
// rises only when all five stages hold items.
// ----------------------------------------------------------------------------
`default_nettype none

module mp3_frame_header_decode (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [31:0] header_word,
	input  wire         id3_present,
	input  wire  [31:0] id3_size_word,
	input  wire         tag_present,
	input  wire  [31:0] audio_length,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [2:0]  status,
	output logic [1:0]  version_code,
	output logic [1:0]  layer_number,
	output logic        protection_bit,
	output logic [8:0]  bitrate_kbps,
	output logic [15:0] sample_rate_hz,
	output logic        padding_flag,
	output logic [11:0] frame_bytes,
	output logic [31:0] duration_ms
);
	import mfhd_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	// stage handshake
	assign rdy5     = !v_s5 || !out_stall;
	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// header decode
	logic [7:0]  b0, b1, b2;
	logic [1:0]  ver, lay, hz, k;
	logic [3:0]  br, c;
	logic        grp;
	logic [2:0]  stat;
	logic [8:0]  kbps;
	side_t       side_c;
	logic [19:0] xfb;
	logic [7:0]  dfb;
	logic [2:0]  sh;
	logic [28:0] id3_sz, sum_td;
	logic [7:0]  tag_sz;
	logic [5:0]  mdiv;
	logic [2:0]  e;
	logic [5:0]  o;

	assign b0  = header_word[31:24];
	assign b1  = header_word[23:16];
	assign b2  = header_word[15:8];
	assign ver = b1[4:3];
	assign lay = 2'd3 - b1[2:1];
	assign br  = b2[7:4];
	assign hz  = b2[3:2];
	assign grp = (ver != VER_1);

	always_comb begin
		if (b0 != 8'hff || b1[7:5] != 3'b111 || b2[7:4] == 4'hf) stat = STAT_SYNC;
		else if (ver == VER_RSVD)                              stat = STAT_VERSION;
		else if (lay == 2'd3)                                  stat = STAT_LAYER;
		else if (br == 4'd0 || br == 4'hf)                     stat = STAT_BITRATE;
		else if (hz == 2'd3)                                   stat = STAT_RATE;
		else                                                   stat = STAT_OK;
	end

	assign kbps = kbps_lookup(grp, lay, br);
	assign c    = coef_div12(grp, lay);
	assign k    = (ver == VER_1) ? 2'd2 : ((ver == VER_2) ? 2'd1 : 2'd0);

	// frame size as a quotient by one or by 147 for the 11025 Hz family, then a shift
	always_comb begin
		case (hz)
			HZ_BASE32: begin
				xfb = 20'd12 * {16'd0, c} * {11'd0, kbps};
				dfb = 8'd1;
				sh  = {1'b0, k} + 3'd3;
			end
			HZ_BASE48: begin
				xfb = {16'd0, c} * {11'd0, kbps};
				dfb = 8'd1;
				sh  = {1'b0, k};
			end
			default: begin
				xfb = 20'd160 * {16'd0, c} * {11'd0, kbps};
				dfb = DIV_11K;
				sh  = {1'b0, k};
			end
		endcase
	end

	// bytes taken off the audio length
	assign id3_sz = id3_present ? ({1'b0, id3_size_word[30:24], id3_size_word[22:16],
	                                 id3_size_word[14:8], id3_size_word[6:0]} + 29'd10)
	                            : 29'd0;
	assign tag_sz = (tag_present && audio_length > 32'd128) ? 8'd128 : 8'd0;
	assign sum_td = id3_sz + {21'd0, tag_sz};

	// bitrate is 8 * 2^e * o with o odd
	assign mdiv = kbps[8:3];
	assign e    = tz6(mdiv);
	assign o    = mdiv >> e;

	always_comb begin
		side_c           = '0;
		side_c.status    = stat;
		side_c.ver       = ver;
		side_c.layer_num = lay + 2'd1;
		side_c.prot      = b1[0];
		side_c.kbps      = kbps;
		side_c.rate      = rate_lookup(ver, hz);
		side_c.pad       = b2[1];
		side_c.sh        = sh;
		side_c.slot4     = (lay == 2'd0);
	end

	side_t       side_s1, side_s2, side_s3, side_s4, side_s5;
	logic [19:0] xfb_s1;
	logic [7:0]  dfb_s1;
	logic [28:0] sum_s1;
	logic [31:0] audio_s1;
	logic [2:0]  e_s1;
	logic [5:0]  o_s1;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			side_s1  <= side_c;
			xfb_s1   <= xfb;
			dfb_s1   <= dfb;
			sum_s1   <= sum_td;
			audio_s1 <= audio_length;
			e_s1     <= e;
			o_s1     <= o;
		end
	end

	// net length, saturating, and the dividend of the play time
	logic [31:0] net, net_sh;

	assign net    = (audio_s1 > {3'd0, sum_s1}) ? audio_s1 - {3'd0, sum_s1} : 32'd0;
	assign net_sh = net >> ({2'd0, e_s1} + 5'd3);

	logic [28:0] xdur_s2, xfb_s2;
	logic [7:0]  ddur_s2, dfb_s2;
	logic [31:0] mdur_s2, mfb_s2;

	always_ff @(posedge clk) begin
		if (rdy2) begin
			side_s2 <= side_s1;
			xdur_s2 <= net_sh[28:0];
			ddur_s2 <= {2'd0, o_s1};
			mdur_s2 <= recip({2'd0, o_s1});
			xfb_s2  <= {9'd0, xfb_s1};
			dfb_s2  <= dfb_s1;
			mfb_s2  <= recip(dfb_s1);
		end
	end

	// side fields follow the divider stages
	always_ff @(posedge clk) begin
		if (rdy3) side_s3 <= side_s2;
		if (rdy4) side_s4 <= side_s3;
		if (rdy5) side_s5 <= side_s4;
	end

	div_ctl_t    dctl;
	logic [28:0] q_dur, q_fb;

	assign dctl.en1 = rdy3;
	assign dctl.en2 = rdy4;
	assign dctl.en3 = rdy5;

	mfhd_recip_div u_div_dur (
		.clk (clk),
		.ctl (dctl),
		.x   (xdur_s2),
		.d   (ddur_s2),
		.m   (mdur_s2),
		.q   (q_dur)
	);

	mfhd_recip_div u_div_fb (
		.clk (clk),
		.ctl (dctl),
		.x   (xfb_s2),
		.d   (dfb_s2),
		.m   (mfb_s2),
		.q   (q_fb)
	);

	// result assembly, all fields but status zero on an error
	logic [28:0] fb_q, fb_sum, fb_full;
	logic        ok;

	assign fb_q    = q_fb >> side_s5.sh;
	assign fb_sum  = fb_q + {28'd0, side_s5.pad};
	assign fb_full = side_s5.slot4 ? (fb_sum << 2) : fb_sum;
	assign ok      = (side_s5.status == STAT_OK);

	assign out_valid      = v_s5;
	assign status         = side_s5.status;
	assign version_code   = ok ? side_s5.ver : 2'd0;
	assign layer_number   = ok ? side_s5.layer_num : 2'd0;
	assign protection_bit = ok & side_s5.prot;
	assign bitrate_kbps   = ok ? side_s5.kbps : 9'd0;
	assign sample_rate_hz = ok ? side_s5.rate : 16'd0;
	assign padding_flag   = ok & side_s5.pad;
	assign frame_bytes    = ok ? fb_full[11:0] : 12'd0;
	assign duration_ms    = ok ? {q_dur, 3'b000} : 32'd0;

`ifndef SYNTHESIS
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != STAT_OK) |-> (bitrate_kbps == 9'd0 && frame_bytes == 12'd0
			&& duration_ms == 32'd0 && sample_rate_hz == 16'd0))
		else $error("error result carries nonzero fields");
	a_ok_rate: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == STAT_OK) |-> (bitrate_kbps != 9'd0 && sample_rate_hz != 16'd0))
		else $error("good header with zero bitrate or rate");
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && out_stall))
		else $error("input stalled while the pipeline has room");
`endif

endmodule

`default_nettype wire

// ===== sim/mfhd_checker.sv =====
// ----------------------------------------------------------------------------
// mfhd_checker
// Watches both channels of the frame header decoder, predicts each result
// from the accepted header item and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module mfhd_checker (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	input  wire         in_stall,
	input  wire  [31:0] header_word,
	input  wire         id3_present,
	input  wire  [31:0] id3_size_word,
	input  wire         tag_present,
	input  wire  [31:0] audio_length,
	input  wire         out_valid,
	input  wire         out_stall,
	input  wire  [2:0]  status,
	input  wire  [1:0]  version_code,
	input  wire  [1:0]  layer_number,
	input  wire         protection_bit,
	input  wire  [8:0]  bitrate_kbps,
	input  wire  [15:0] sample_rate_hz,
	input  wire         padding_flag,
	input  wire  [11:0] frame_bytes,
	input  wire  [31:0] duration_ms,
	output int          fail_count,
	output int          pending
);
	import mfhd_pkg::*;

	typedef struct packed {
		logic [2:0]  status;
		logic [1:0]  ver;
		logic [1:0]  layer;
		logic        prot;
		logic [8:0]  kbps;
		logic [15:0] rate;
		logic        pad;
		logic [11:0] bytes;
		logic [31:0] dur;
	} decoded_t;

	decoded_t expected_q[$];

	// bitrate tables, mpeg1 then mpeg2/2.5, per layer index
	localparam int MP1_KBPS [3][16] = '{
		'{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0},
		'{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
		'{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0}};
	localparam int MP2_KBPS [3][16] = '{
		'{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0},
		'{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0},
		'{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0}};

	function automatic decoded_t decode_header(input logic [31:0] hdr, input logic id3_on,
	                                           input logic [31:0] id3_w, input logic tag_on,
	                                           input logic [31:0] len);
		decoded_t d;
		logic [7:0] b0, b1, b2;
		logic [1:0] ver, hz;
		int lay, br, kbps, rate, coef, slot;
		longint unsigned tag, id3, net, fb;
		d = '0;
		b0 = hdr[31:24];
		b1 = hdr[23:16];
		b2 = hdr[15:8];
		ver = b1[4:3];
		lay = 3 - int'(b1[2:1]);
		br = int'(b2[7:4]);
		hz = b2[3:2];
		if (b0 != 8'hff || b1[7:5] != 3'b111 || b2[7:4] == 4'hf)
			d.status = STAT_SYNC;
		else if (ver == VER_RSVD)
			d.status = STAT_VERSION;
		else if (lay == 3)
			d.status = STAT_LAYER;
		else if (br == 0 || br == 15)
			d.status = STAT_BITRATE;
		else if (hz == 2'd3)
			d.status = STAT_RATE;
		else
			d.status = STAT_OK;
		if (d.status != STAT_OK) return d;
		kbps = (ver == VER_1) ? MP1_KBPS[lay][br] : MP2_KBPS[lay][br];
		case (hz)
			HZ_BASE44: rate = 44100;
			HZ_BASE48: rate = 48000;
			default:   rate = 32000;
		endcase
		if (ver == VER_2) rate = rate / 2;
		if (ver == VER_25) rate = rate / 4;
		coef = (lay == 0) ? 12 : (lay == 2 && ver != VER_1) ? 72 : 144;
		slot = (lay == 0) ? 4 : 1;
		fb = (longint'(coef) * kbps * 1000 / rate + b2[1]) * slot;
		tag = (tag_on && len > 128) ? 128 : 0;
		id3 = id3_on ? ({id3_w[30:24], id3_w[22:16], id3_w[14:8], id3_w[6:0]} + 10) : 0;
		net = (len > tag + id3) ? len - tag - id3 : 0;
		d.ver = ver;
		d.layer = 2'(lay + 1);
		d.prot = b1[0];
		d.kbps = 9'(kbps);
		d.rate = 16'(rate);
		d.pad = b2[1];
		d.bytes = fb[11:0];
		d.dur = 32'((net / kbps) * 8);
		return d;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
		fail_count++;
	endtask

	assign pending = expected_q.size();

	initial fail_count = 0;

	// queue each accepted item, check each accepted result
	always @(posedge clk) begin
		decoded_t w;
		if (arst_n && in_valid && !in_stall)
			expected_q.push_back(decode_header(header_word, id3_present, id3_size_word,
			                                   tag_present, audio_length));
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$display("%0t unexpected result item", $time);
				fail_count++;
			end else begin
				w = expected_q.pop_front();
				if (status != w.status) report_mismatch("status", status, w.status);
				if (version_code != w.ver) report_mismatch("version", version_code, w.ver);
				if (layer_number != w.layer) report_mismatch("layer", layer_number, w.layer);
				if (protection_bit != w.prot) report_mismatch("prot", protection_bit, w.prot);
				if (bitrate_kbps != w.kbps) report_mismatch("kbps", bitrate_kbps, w.kbps);
				if (sample_rate_hz != w.rate) report_mismatch("rate", sample_rate_hz, w.rate);
				if (padding_flag != w.pad) report_mismatch("pad", padding_flag, w.pad);
				if (frame_bytes != w.bytes) report_mismatch("bytes", frame_bytes, w.bytes);
				if (duration_ms != w.dur) report_mismatch("duration", duration_ms, w.dur);
			end
		end
	end

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the frame header decoder: directed corner headers, then
// mostly well-formed random headers under several idle and stall mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
	import mfhd_pkg::*;

	logic        clk, arst_n;
	logic        in_valid, out_stall;
	logic [31:0] header_word, id3_size_word, audio_length;
	logic        id3_present, tag_present;
	wire         in_stall, out_valid, protection_bit, padding_flag;
	wire  [2:0]  status;
	wire  [1:0]  version_code, layer_number;
	wire  [8:0]  bitrate_kbps;
	wire  [15:0] sample_rate_hz;
	wire  [11:0] frame_bytes;
	wire  [31:0] duration_ms;
	int          fail_count, pending;
	int          send_idle_pct, stall_pct;

	mp3_frame_header_decode dut (.*);

	mfhd_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("tb_top NOT OK");
		$finish;
	end

	// receiver stall
	always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

	// drive one item and hold it until accepted
	task automatic send_header(input logic [31:0] hdr, input logic id3_on,
	                           input logic [31:0] id3_w, input logic tag_on,
	                           input logic [31:0] len);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		header_word <= hdr;
		id3_present <= id3_on;
		id3_size_word <= id3_w;
		tag_present <= tag_on;
		audio_length <= len;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// random header, mostly with sync and legal codes
	function automatic logic [31:0] random_header();
		logic [31:0] h;
		h = $urandom;
		if ($urandom_range(9) < 8) begin
			h[31:21] = 11'h7ff;
			if ($urandom_range(9) < 8) begin
				if (h[20:19] == VER_RSVD) h[20:19] = VER_1;
				if (h[18:17] == 2'd0) h[18:17] = 2'd1;
				if (h[15:12] == 4'h0 || h[15:12] == 4'hf) h[15:12] = 4'($urandom_range(14, 1));
				if (h[11:10] == 2'd3) h[11:10] = 2'($urandom_range(2));
			end
		end
		return h;
	endfunction

	function automatic logic [31:0] random_length();
		case ($urandom_range(3))
			0: return $urandom_range(300);
			1: return $urandom_range(1 << 20);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int ph, lay, br;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		header_word = '0;
		id3_present = 1'b0;
		id3_size_word = '0;
		tag_present = 1'b0;
		audio_length = '0;
		send_idle_pct = 0;
		stall_pct = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// each error kind
		send_header(32'h0000_0000, 1'b0, 32'd0, 1'b0, 32'd0);
		send_header(32'hfffb_f000, 1'b0, 32'd0, 1'b0, 32'd1000);
		send_header(32'hffe8_9000, 1'b0, 32'd0, 1'b0, 32'd1000);
		send_header(32'hfff9_9000, 1'b0, 32'd0, 1'b0, 32'd1000);
		send_header(32'hfffb_0000, 1'b0, 32'd0, 1'b0, 32'd1000);
		send_header(32'hfffb_9c00, 1'b0, 32'd0, 1'b0, 32'd1000);
		// every version and layer, highest and lowest bitrates, with and without padding
		for (lay = 1; lay < 4; lay++) begin
			send_header({11'h7ff, VER_1, 2'(lay), 1'b1, 4'd14, HZ_BASE32, 1'b1, 9'd0},
			            1'b1, 32'h7f7f_7f7f, 1'b1, 32'hffff_ffff);
			send_header({11'h7ff, VER_2, 2'(lay), 1'b0, 4'd1, HZ_BASE48, 1'b1, 9'd0},
			            1'b0, 32'hffff_ffff, 1'b1, 32'd128);
			send_header({11'h7ff, VER_25, 2'(lay), 1'b1, 4'd1, HZ_BASE32, 1'b0, 9'h1ff},
			            1'b1, 32'h0000_0000, 1'b1, 32'd129);
		end
		// audio at or below tag plus id3 size, then a tag on the largest length
		send_header(32'hfffb_9000, 1'b1, 32'h0000_0001, 1'b1, 32'd138);
		send_header(32'hfffb_9000, 1'b1, 32'h8080_8080, 1'b0, 32'd10);
		send_header(32'hfffb_9000, 1'b0, 32'd0, 1'b1, 32'hffff_ffff);

		// random items over four idle and stall phases
		for (ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 67 : 20) : 0;
			stall_pct = (ph == 2) ? 67 : (ph == 3) ? 20 : 0;
			for (br = 0; br < 160; br++)
				send_header(random_header(), 1'($urandom_range(1)), $urandom,
				            1'($urandom_range(1)), random_length());
		end
		in_valid <= 1'b0;
		stall_pct = 0;
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
src/mfhd_pkg.sv
src/mfhd_recip_div.sv
src/mp3_frame_header_decode.sv
sim/mfhd_checker.sv
sim/tb_top.sv
